/* src/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg: shared types and constants of the ordered list engine
// Sizes, request and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int LIST_CAPACITY = 64;
   localparam int ADDR_W        = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int INDEX_W       = 6;
   localparam int COUNT_OUT_W   = 7;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_HEAD   = 3'd1,
      OP_TAIL   = 3'd2,
      OP_DELETE = 3'd3,
      OP_SEARCH = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // one write port and one read port of the element store
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   // finished result word from the sequencer
   typedef struct packed {
      status_type              status;
      data_type                removed;
      logic [INDEX_W-1:0]      index;
      logic [COUNT_OUT_W-1:0]  count;
   } res_type;

endpackage

/* src/olist_req_if.sv */
// ----------------------------------------------------------------------------
// olist_req_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface olist_req_if;
   import olist_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     req_type;
   data_type            item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

/* src/olist_rsp_if.sv */
// ----------------------------------------------------------------------------
// olist_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface olist_rsp_if;
   import olist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   data_type                 removed_value;
   logic [INDEX_W-1:0]       found_index;
   logic [COUNT_OUT_W-1:0]   element_count;

   modport source (output valid, output status, output removed_value,
                   output found_index, output element_count, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input found_index, input element_count, output ready);
endinterface

/* src/olist_store.sv */
// ----------------------------------------------------------------------------
// olist_store: element store
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module olist_store (
   input  logic                 clock,
   input  olist_pkg::mem_req_type mem_req,
   output olist_pkg::data_type  rd_data
);
   import olist_pkg::*;

   data_type mem [LIST_CAPACITY];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/olist_seq.sv */
// ----------------------------------------------------------------------------
// olist_seq: list sequencer
// Pipelined scan of the store with one shared comparator, then a gap-closing
// shift pass; holds the fill count and the result word.
// ----------------------------------------------------------------------------
module olist_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [olist_pkg::OP_W-1:0] req_op,
   input  olist_pkg::data_type     req_value,
   output logic                    req_ready,
   output olist_pkg::mem_req_type  mem_req,
   input  olist_pkg::data_type     rd_data,
   output logic                    res_valid,
   output olist_pkg::res_type      res,
   input  logic                    res_take
);
   import olist_pkg::*;

   localparam cnt_type CAP_COUNT = CNT_W'(LIST_CAPACITY);

   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   data_type         value_ff, value_in;
   cnt_type          rd_ptr_ff, rd_ptr_in;
   addr_type         pos_ff, pos_in;       // position of the word in rd_data
   logic             pend_ff, pend_in;     // rd_data holds a fresh word
   cnt_type          count_ff, count_in;
   status_type       status_ff, status_in;
   data_type         removed_ff, removed_in;
   addr_type         index_ff, index_in;
   logic             issue;
   logic             match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         rd_ptr_ff <= '0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         rd_ptr_ff <= rd_ptr_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      index_ff   <= index_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      rd_ptr_in  = rd_ptr_ff;
      pos_in     = pos_ff;
      pend_in    = 1'b0;
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      index_in   = index_ff;
      mem_req    = '0;
      match      = 1'b0;

      // read pipeline: one address a cycle while positions remain
      issue = ((state_ff == ST_SCAN) || (state_ff == ST_SHIFT)) && (rd_ptr_ff < count_ff);
      if (issue) begin
         mem_req.rd_en   = 1'b1;
         mem_req.rd_addr = rd_ptr_ff[ADDR_W-1:0];
         rd_ptr_in       = rd_ptr_ff + CNT_W'(1);
         pos_in          = rd_ptr_ff[ADDR_W-1:0];
         pend_in         = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               value_in   = req_value;
               status_in  = STATUS_OK;
               removed_in = '0;
               index_in   = '0;
               rd_ptr_in  = '0;
               state_in   = ST_FINISH;
               case (req_op)
                  OP_APPEND: begin
                     if (count_ff >= CAP_COUNT) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[ADDR_W-1:0];
                        mem_req.wr_data = req_value;
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  OP_HEAD, OP_TAIL: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                        if (req_op == OP_TAIL) begin
                           rd_ptr_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  OP_DELETE, OP_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // head and tail take the first word read; others need equality
            match = pend_ff && ((op_ff inside {OP_HEAD, OP_TAIL}) || (rd_data == value_ff));
            if (match) begin
               if (op_ff == OP_SEARCH) begin
                  index_in = pos_ff;
                  state_in = ST_FINISH;
               end else begin
                  removed_in = rd_data;
                  state_in   = ST_SHIFT;
               end
            end else if (!pend_ff && !issue) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            // the read after the match is already in flight: move each word up
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff - ADDR_W'(1);
               mem_req.wr_data = rd_data;
            end else if (!issue) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign res_valid   = (state_ff == ST_FINISH);
   assign res.status  = status_ff;
   assign res.removed = removed_ff;
   assign res.index   = INDEX_W'(index_ff);
   assign res.count   = COUNT_OUT_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("fill count above capacity");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> ((state_ff == ST_IDLE) || (state_ff == ST_SHIFT)))
      else $error("store written outside append or shift");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && pend_ff) |-> (pos_ff != '0))
      else $error("shift would write below the head");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && (state_in == ST_FINISH))
      |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("removal did not drop the count by one");

   a_take_finish: assert property (@(posedge clock) disable iff (reset)
      res_take |-> (state_ff == ST_FINISH))
      else $error("result taken before it was finished");

endmodule

/* src/ordered_list_engine.sv */
// Append, refused requests and unused codes finish without a pass over the store.
// Removals and delete run a one-word-a-cycle scan of the store, then a
// one-word-a-cycle shift to close the gap; search runs the scan only.
// One request at a time: the next is taken once the result word enters the output register.
// Reset (synchronous, active high) empties the list; store contents are left as they are.
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit values
// Append at tail, remove head or tail, delete first match, search first match.
// ----------------------------------------------------------------------------
module ordered_list_engine (
   input  logic         clock,
   input  logic         reset,
   olist_req_if.sink    req_ch,
   olist_rsp_if.source  rsp_ch
);
   import olist_pkg::*;

   mem_req_type mem_req;
   data_type    rd_data;
   logic        res_valid;
   res_type     res;
   logic        res_take;
   logic        out_free;

   // output register: parts the sequencer from a stalled sink
   logic        rsp_vld_ff, rsp_vld_in;
   res_type     rsp_res_ff, rsp_res_in;

   olist_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   olist_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.req_type),
      .req_value (req_ch.item_value),
      .req_ready (req_ch.ready),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // a finished word moves out when the register is empty or being drained
   always_comb begin
      out_free   = !rsp_vld_ff || rsp_ch.ready;
      res_take   = res_valid && out_free;
      rsp_vld_in = rsp_vld_ff;
      rsp_res_in = rsp_res_ff;
      if (res_take) begin
         rsp_vld_in = 1'b1;
         rsp_res_in = res;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.status        = rsp_res_ff.status;
   assign rsp_ch.removed_value = rsp_res_ff.removed;
   assign rsp_ch.found_index   = rsp_res_ff.index;
   assign rsp_ch.element_count = rsp_res_ff.count;

endmodule
